// ===== rtl/pixel_arith_calibrate_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PIXEL_ARITH_CALIBRATE_DEFINES_SVH
`define PIXEL_ARITH_CALIBRATE_DEFINES_SVH

// Implication in the same cycle, ignored while reset is asserted.
`define PAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pac assertion failed");

// Implication into the next cycle, ignored while reset is asserted.
`define PAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pac assertion failed");

// Implication into the next cycle that also holds through reset.
`define PAC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pac assertion failed");

`endif

// ===== rtl/pac_pkg.sv =====
// ----------------------------------------------------------------------------
// pac_pkg
// Types and constants shared by the pixel calibration arithmetic block.
// ----------------------------------------------------------------------------
`default_nettype none

package pac_pkg;

  localparam int PORT_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    MODE_ADD_CONST   = 3'd0,
    MODE_SCALE_CONST = 3'd1,
    MODE_ADD_IMG     = 3'd2,
    MODE_SUB_IMG     = 3'd3,
    MODE_MUL_IMG     = 3'd4,
    MODE_DIV_IMG     = 3'd5,
    MODE_FLAT        = 3'd6,
    MODE_THERMAL     = 3'd7
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THERMAL = 2'd3;

  // Control travelling alongside each word through the pipeline.
  typedef struct packed {
    logic vld;   // word present in this stage
    logic dv;    // word takes the divide path
    logic zd;    // divisor was zero
    logic ovf;   // quotient exceeds the pixel range
    logic clip;  // clip flag of a non-divide result
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pac_front.sv =====
// ----------------------------------------------------------------------------
// pac_front
// Input stages: products, then the fixed-point sum with its rounding and
// clamping, and the dividend and divisor set-up for the divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_front
  import pac_pkg::*;
#(
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  en,
  input  wire logic                                  in_vld,
  input  wire logic [PIXEL_BITS-1:0]                 p1,
  input  wire logic [PIXEL_BITS-1:0]                 p2,
  input  mode_t                                      mode,
  input  wire logic signed [CFG_W-1:0]               cst,
  input  wire logic [CFG_W-1:0]                      mean,
  input  wire logic [CFG_W-1:0]                      factor,
  output ctl_t                                       ctl_o,
  output logic [PIXEL_BITS+CFG_W-1:0]                rem_o,
  output logic [PIXEL_BITS+FRACTION_BITS-1:0]        den_o,
  output logic [PIXEL_BITS-1:0]                      res_o
);

  localparam int P     = PIXEL_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int NUM_W = P + CFG_W;
  localparam int DEN_W = P + F;
  localparam int CW    = (NUM_W > 2*P+F) ? NUM_W : 2*P+F;
  localparam int VW    = ((2*P+F) > (P+CFG_W+1) ? (2*P+F) : (P+CFG_W+1)) + 2;
  localparam int SW    = P + CFG_W + 1;

  logic                   vld_a_r;
  logic [P-1:0]           p1_a_r, p2_a_r;
  logic signed [SW-1:0]   prod_s_r, prod_s_nxt;
  logic [2*P-1:0]         prod_pp_r;
  logic [NUM_W-1:0]       prod_th_r, prod_fm_r;

  ctl_t                   ctl_b_r, ctl_b_nxt;
  logic [NUM_W-1:0]       num_b_r, num_b_nxt;
  logic [DEN_W-1:0]       den_b_r, den_b_nxt;
  logic [P-1:0]           res_b_r, res_b_nxt;

  logic signed [VW-1:0]   t_p1, v, v_rnd, max_q;

  assign prod_s_nxt = SW'($signed({1'b0, p1})) * SW'(cst);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
    end
    if (en) begin
      p1_a_r    <= p1;
      p2_a_r    <= p2;
      prod_s_r  <= prod_s_nxt;
      prod_pp_r <= (2*P)'(p1) * (2*P)'(p2);
      prod_th_r <= NUM_W'(p2) * NUM_W'(factor);
      prod_fm_r <= NUM_W'(p1) * NUM_W'(mean);
    end
  end

  always_comb begin
    t_p1 = VW'(p1_a_r) << F;
    case (mode)
      MODE_ADD_CONST:   v = t_p1 + VW'(cst);
      MODE_SCALE_CONST: v = VW'(prod_s_r);
      MODE_ADD_IMG:     v = (VW'(p1_a_r) + VW'(p2_a_r)) << F;
      MODE_SUB_IMG:     v = t_p1 - (VW'(p2_a_r) << F);
      MODE_MUL_IMG:     v = VW'(prod_pp_r) << F;
      MODE_THERMAL:     v = t_p1 - VW'(prod_th_r);
      default:          v = '0;
    endcase
    max_q = VW'({P{1'b1}}) << F;
    v_rnd = v + (VW'(1) << (F-1));

    ctl_b_nxt      = '0;
    ctl_b_nxt.vld  = vld_a_r;
    ctl_b_nxt.dv   = (mode == MODE_DIV_IMG) || (mode == MODE_FLAT);
    ctl_b_nxt.zd   = (p2_a_r == '0);
    if (v[VW-1]) begin
      res_b_nxt      = '0;
      ctl_b_nxt.clip = 1'b1;
    end else if (v > max_q) begin
      res_b_nxt      = '1;
      ctl_b_nxt.clip = 1'b1;
    end else begin
      res_b_nxt      = v_rnd[F+P-1:F];
    end

    // Divide image is scaled by the fraction so both divide modes share one
    // divisor, the operand pixel with the fraction appended.
    num_b_nxt     = (mode == MODE_FLAT) ? prod_fm_r : (NUM_W'(p1_a_r) << F);
    den_b_nxt     = DEN_W'(p2_a_r) << F;
    ctl_b_nxt.ovf = CW'(num_b_nxt) >= (CW'(den_b_nxt) << P);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_b_nxt;
    end
    if (en) begin
      num_b_r <= num_b_nxt;
      den_b_r <= den_b_nxt;
      res_b_r <= res_b_nxt;
    end
  end

  assign ctl_o = ctl_b_r;
  assign rem_o = num_b_r;
  assign den_o = den_b_r;
  assign res_o = res_b_r;

endmodule

`default_nettype wire

// ===== rtl/pac_div_cell.sv =====
// ----------------------------------------------------------------------------
// pac_div_cell
// One restoring-division cell: settles one quotient bit and hands the
// partial remainder and the word's side data to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pac_div_cell
  import pac_pkg::*;
#(
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 16,
  parameter int SHIFT         = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  ctl_t                                    ctl_i,
  input  wire logic [PIXEL_BITS+CFG_W-1:0]        rem_i,
  input  wire logic [PIXEL_BITS+FRACTION_BITS-1:0] den_i,
  input  wire logic [PIXEL_BITS-1:0]              q_i,
  input  wire logic [PIXEL_BITS-1:0]              res_i,
  output ctl_t                                    ctl_o,
  output logic [PIXEL_BITS+CFG_W-1:0]             rem_o,
  output logic [PIXEL_BITS+FRACTION_BITS-1:0]     den_o,
  output logic [PIXEL_BITS-1:0]                   q_o,
  output logic [PIXEL_BITS-1:0]                   res_o
);

  localparam int P     = PIXEL_BITS;
  localparam int NUM_W = P + CFG_W;
  localparam int DEN_W = P + FRACTION_BITS;
  localparam int CW    = (NUM_W > 2*P+FRACTION_BITS) ? NUM_W : 2*P+FRACTION_BITS;

  ctl_t             ctl_r;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [P-1:0]     q_r, q_nxt, res_r;
  logic [CW-1:0]    dsh;
  logic             ge;

  always_comb begin
    dsh     = CW'(den_i) << SHIFT;
    ge      = CW'(rem_i) >= dsh;
    rem_nxt = ge ? NUM_W'(CW'(rem_i) - dsh) : rem_i;
    q_nxt   = {q_i[P-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
      res_r <= res_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;
  assign res_o = res_r;

endmodule

`default_nettype wire

// ===== rtl/pixel_arith_calibrate.sv =====
// ----------------------------------------------------------------------------
// pixel_arith_calibrate
// Per-pixel calibration arithmetic with a chain of divider cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Word
// in        input      in_valid/in_ready    image pixel, operand pixel
// out       output     out_valid/out_ready  result pixel, clip flag
// cfg       input      cfg_write_en         register index, data
//
// One word is taken per cycle unless the output stalls; each word passes through
// two input stages, one divider cell per quotient bit, and the output stage.
// A stalled output word freezes the whole pipe and drops in_ready.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_arith_calibrate
  import pac_pkg::*;
#(
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PORT_W-1:0]    in_image_pixel,
  input  wire logic [PORT_W-1:0]    in_operand_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PORT_W-1:0]         out_result_pixel,
  output logic                      out_clipped,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int P     = PIXEL_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int NUM_W = P + CFG_W;
  localparam int DEN_W = P + F;

  mode_t             mode_r;
  logic [CFG_W-1:0]  cst_r, mean_r, factor_r;
  logic              en;

  ctl_t              ctl_c [P+1];
  logic [NUM_W-1:0]  rem_c [P+1];
  logic [DEN_W-1:0]  den_c [P+1];
  logic [P-1:0]      q_c   [P+1];
  logic [P-1:0]      res_c [P+1];

  logic              out_vld_r;
  logic [P-1:0]      out_pix_r, out_pix_nxt;
  logic              out_clip_r, out_clip_nxt;
  logic              half_up, q_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ADD_CONST;
      cst_r    <= '0;
      mean_r   <= CFG_W'(1) << F;
      factor_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MODE:    mode_r   <= mode_t'(cfg_data[2:0]);
        REG_CONST:   cst_r    <= cfg_data;
        REG_MEAN:    mean_r   <= cfg_data;
        REG_THERMAL: factor_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  pac_front #(.PIXEL_BITS(P), .FRACTION_BITS(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .p1     (in_image_pixel[P-1:0]),
    .p2     (in_operand_pixel[P-1:0]),
    .mode   (mode_r),
    .cst    ($signed(cst_r)),
    .mean   (mean_r),
    .factor (factor_r),
    .ctl_o  (ctl_c[0]),
    .rem_o  (rem_c[0]),
    .den_o  (den_c[0]),
    .res_o  (res_c[0])
  );

  assign q_c[0] = '0;

  for (genvar k = 0; k < P; k++) begin : g_cell
    pac_div_cell #(.PIXEL_BITS(P), .FRACTION_BITS(F), .SHIFT(P-1-k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .den_i (den_c[k]),
      .q_i   (q_c[k]),
      .res_i (res_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .den_o (den_c[k+1]),
      .q_o   (q_c[k+1]),
      .res_o (res_c[k+1])
    );
  end

  // Round half up from the remainder; a full quotient with any remainder
  // left over lies above the pixel maximum.
  always_comb begin
    half_up = ((NUM_W+1)'(rem_c[P]) << 1) >= (NUM_W+1)'(den_c[P]);
    q_top   = (q_c[P] == '1) && (rem_c[P] != '0);
    if (!ctl_c[P].dv) begin
      out_pix_nxt  = res_c[P];
      out_clip_nxt = ctl_c[P].clip;
    end else if (ctl_c[P].zd || ctl_c[P].ovf || q_top) begin
      out_pix_nxt  = '1;
      out_clip_nxt = 1'b1;
    end else begin
      out_pix_nxt  = q_c[P] + P'(half_up);
      out_clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_c[P].vld;
    end
    if (en) begin
      out_pix_r  <= out_pix_nxt;
      out_clip_r <= out_clip_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_pixel = PORT_W'(out_pix_r);
  assign out_clipped      = out_clip_r;

endmodule

`default_nettype wire

// ===== rtl/pac_checker.sv =====
// ----------------------------------------------------------------------------
// pac_checker
// Port-level checks on the pixel calibration block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_arith_calibrate_defines.svh"

module pac_checker
  import pac_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PORT_W-1:0] out_result_pixel,
  input wire logic              out_clipped
);

  // A stalled result word holds its value.
  `PAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_pixel) && $stable(out_clipped))

  // With no word waiting at the output the pipe always takes input.
  `PAC_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // A stalled output freezes the pipe, so no input is taken.
  `PAC_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)

  // Reset empties the output stage.
  `PAC_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind pixel_arith_calibrate pac_checker u_pac_checker (.*);

`default_nettype wire
